/* hdl/matched_filter_fir_macros.svh */
// matched_filter_fir_macros.svh: concurrent assertion macros for the filter
// no dependencies; expects clk and rst in the scope of each use
`ifndef MATCHED_FILTER_FIR_MACROS_SVH
`define MATCHED_FILTER_FIR_MACROS_SVH

// condition and property checked in the same cycle
`define MFF_ASSERT_SAME(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// property checked in the cycle after the condition
`define MFF_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* hdl/mff_pkg.sv */
`timescale 1ns / 1ps
// mff_pkg: shared widths, op codes and the cell control bundle
// no dependencies
package mff_pkg;

  localparam int TAP_W  = 16;
  localparam int FILT_W = 36;
  localparam int KLEN_W = 5;
  localparam int TIDX_W = 4;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic advance;
    logic push;
    logic clear;
    logic load;
    logic rotate;
  } cell_ctrl_t;

endpackage

/* hdl/mff_cell.sv */
`timescale 1ns / 1ps
// mff_cell: one filter cell with a delayed sample (when KEEP_SAMPLE is set), a rotating tap and a product
// depends on mff_pkg
module mff_cell import mff_pkg::*; #(
  parameter int MAX_TAPS    = 16,
  parameter int SAMPLE_BITS = 16,
  parameter int POS         = 0,
  parameter bit KEEP_SAMPLE = 1'b1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  cell_ctrl_t                         ctrl,
  input  logic [$clog2(MAX_TAPS)-1:0]        rot_pos,
  input  logic [TIDX_W-1:0]                  tap_index,
  input  logic signed [TAP_W-1:0]            tap_value,
  input  logic signed [SAMPLE_BITS-1:0]      win,
  input  logic signed [TAP_W-1:0]            coef_in,
  output logic signed [TAP_W-1:0]            coef_out,
  output logic signed [SAMPLE_BITS-1:0]      samp_out,
  output logic signed [FILT_W-1:0]           prod
);

  localparam int IDXW = $clog2(MAX_TAPS);
  localparam logic [IDXW-1:0] POS_V  = IDXW'(POS);
  localparam logic [IDXW-1:0] WRAP_V = IDXW'(MAX_TAPS - POS);

  logic [IDXW-1:0]                    my_idx;
  logic                               active;
  logic                               write_hit;
  logic signed [TAP_W-1:0]            coef;
  logic signed [SAMPLE_BITS+TAP_W-1:0] mult;

  // tap number this cell currently holds, (rot_pos - POS) mod MAX_TAPS
  always_comb begin
    if (rot_pos >= POS_V) begin
      my_idx = rot_pos - POS_V;
    end else begin
      my_idx = rot_pos + WRAP_V;
    end
  end

  assign active    = (POS_V <= rot_pos);
  assign write_hit = ctrl.load && (int'(tap_index) == int'(my_idx));
  assign mult      = win * coef;
  assign coef_out  = coef;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (ctrl.rotate) begin
      coef <= coef_in;
    end else if (write_hit) begin
      coef <= tap_value;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      prod <= active ? FILT_W'(mult) : '0;
    end
  end

  if (KEEP_SAMPLE) begin : g_keep
    logic signed [SAMPLE_BITS-1:0] sreg;

    always_ff @(posedge clk) begin
      if (rst) begin
        sreg <= '0;
      end else if (ctrl.push) begin
        sreg <= ctrl.clear ? '0 : win;
      end
    end

    assign samp_out = sreg;
  end else begin : g_end
    assign samp_out = '0;
  end

endmodule

/* hdl/mff_sum_tree.sv */
`timescale 1ns / 1ps
// mff_sum_tree: registered binary adder tree over the cell products
// depends on mff_pkg
module mff_sum_tree import mff_pkg::*; #(
  parameter int N = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [FILT_W-1:0] leaf [N],
  output logic signed [FILT_W-1:0] root
);

  localparam int LEVELS = $clog2(N);
  localparam int NP     = 1 << LEVELS;

  logic signed [FILT_W-1:0] leaf_pad [NP];
  logic signed [FILT_W-1:0] node     [1:NP-1];

  for (genvar i = 0; i < NP; i++) begin : g_leaf
    if (i < N) begin : g_used
      assign leaf_pad[i] = leaf[i];
    end else begin : g_pad
      assign leaf_pad[i] = '0;
    end
  end

  // heap order: node i adds children 2i and 2i+1, the bottom row reads leaves
  for (genvar i = 1; i < NP; i++) begin : g_node
    if (2 * i >= NP) begin : g_bottom
      always_ff @(posedge clk) begin
        if (en) begin
          node[i] <= leaf_pad[2*i-NP] + leaf_pad[2*i+1-NP];
        end
      end
    end else begin : g_inner
      always_ff @(posedge clk) begin
        if (en) begin
          node[i] <= node[2*i] + node[2*i+1];
        end
      end
    end
  end

  assign root = node[1];

endmodule

/* hdl/matched_filter_fir.sv */
`timescale 1ns / 1ps
// matched_filter_fir: streaming matched filter, full convolution with reversed taps
// depends on mff_pkg, mff_cell, mff_sum_tree and matched_filter_fir_macros.svh
//
// usage
//   input channel (in_valid/in_ready): op selects a tap load or a sample push
//   a load request writes tap_value at tap_index and gives no result
//   a sample request gives one filtered result; a sample with last_sample
//   set is followed by (tap count - 1) tail results, the final one marked
//   last_output, and the sample history is then cleared for the next run
//   cfg_we/cfg_wdata write the tap count; write it only while idle
// timing
//   a result's products load on its accepting edge, then the sum passes
//   through each registered adder level in turn before the result is valid
//   one request per cycle while in_ready is high; a last sample holds off input
//   while its tap count - 1 tail results are generated, which output stalls prolong
//   after a tap count write the tap ring rotates one place per cycle
//   and input is held off until it lines up
// reset and stall
//   rst (synchronous) clears history and taps, the tap count reads MAX_TAPS
//   while a result waits with out_ready low the pipe freezes, in_ready drops
`include "matched_filter_fir_macros.svh"
module matched_filter_fir import mff_pkg::*; #(
  parameter int MAX_TAPS    = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [KLEN_W-1:0]             cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic [TIDX_W-1:0]             tap_index,
  input  logic signed [TAP_W-1:0]       tap_value,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          last_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [FILT_W-1:0]      filtered,
  output logic                          last_output
);

  localparam int IDXW = $clog2(MAX_TAPS);
  // product stage plus one stage per tree level
  localparam int PIPE = $clog2(MAX_TAPS) + 1;
  localparam logic [IDXW-1:0] TOP_POS = IDXW'(MAX_TAPS - 1);

  // tap count kept as taps in use minus one, already clamped
  logic [IDXW-1:0] len_m1;
  logic [IDXW-1:0] len_m1_next;
  // current alignment of the tap ring, equals len_m1 when usable
  logic [IDXW-1:0] rot_pos;
  // tail results still to generate after a last sample
  logic [IDXW-1:0] flush_cnt;

  logic aligned;
  logic flushing;
  logic advance;
  logic acc;
  logic acc_load;
  logic acc_samp;
  logic push;
  logic push_last;
  cell_ctrl_t ctrl;

  logic [PIPE-1:0] vld;
  logic [PIPE-1:0] lst;

  logic signed [SAMPLE_BITS-1:0] win      [MAX_TAPS];
  logic signed [TAP_W-1:0]       coef_out [MAX_TAPS];
  logic signed [FILT_W-1:0]      prod     [MAX_TAPS];

  // clamp the written length into 1..MAX_TAPS, store minus one
  always_comb begin
    if (cfg_wdata == '0) begin
      len_m1_next = '0;
    end else if (int'(cfg_wdata) > MAX_TAPS) begin
      len_m1_next = TOP_POS;
    end else begin
      len_m1_next = IDXW'(int'(cfg_wdata) - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_m1 <= TOP_POS;
    end else if (cfg_we) begin
      len_m1 <= len_m1_next;
    end
  end

  // handshake and push control
  assign aligned  = (rot_pos == len_m1);
  assign flushing = (flush_cnt != '0);
  assign advance  = !vld[PIPE-1] || out_ready;
  assign in_ready = advance && !flushing && aligned;
  assign acc      = in_valid && in_ready;
  assign acc_load = acc && (op == OP_LOAD);
  assign acc_samp = acc && (op == OP_SAMPLE);
  assign push     = acc_samp || (flushing && advance);

  // the final push of a run marks its result and clears the history
  assign push_last = flushing ? (flush_cnt == IDXW'(1)) : (last_sample && len_m1 == '0);

  // tail pushes feed zeros into the chain
  assign win[0] = flushing ? '0 : sample;

  assign ctrl.advance = advance;
  assign ctrl.push    = push;
  assign ctrl.clear   = push && push_last;
  assign ctrl.load    = acc_load;
  assign ctrl.rotate  = !aligned;

  // tap ring rotation after a length change, one place per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      rot_pos <= TOP_POS;
    end else if (!aligned) begin
      rot_pos <= (rot_pos == TOP_POS) ? '0 : rot_pos + 1'b1;
    end
  end

  // tail counter, loaded by a last sample and counted down per tail push
  always_ff @(posedge clk) begin
    if (rst) begin
      flush_cnt <= '0;
    end else if (acc_samp && last_sample) begin
      flush_cnt <= len_m1;
    end else if (flushing && advance) begin
      flush_cnt <= flush_cnt - 1'b1;
    end
  end

  // valid and last flags travel alongside the product and tree stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[PIPE-2:0], push};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lst <= {lst[PIPE-2:0], push_last};
    end
  end

  // row of cells: cell j multiplies the lag-j sample by its tap
  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
    if (j < MAX_TAPS - 1) begin : g_mid
      mff_cell #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .POS         (j),
        .KEEP_SAMPLE (1'b1)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .rot_pos   (rot_pos),
        .tap_index (tap_index),
        .tap_value (tap_value),
        .win       (win[j]),
        .coef_in   (coef_out[(j + MAX_TAPS - 1) % MAX_TAPS]),
        .coef_out  (coef_out[j]),
        .samp_out  (win[j+1]),
        .prod      (prod[j])
      );
    end else begin : g_end
      mff_cell #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .POS         (j),
        .KEEP_SAMPLE (1'b0)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .rot_pos   (rot_pos),
        .tap_index (tap_index),
        .tap_value (tap_value),
        .win       (win[j]),
        .coef_in   (coef_out[(j + MAX_TAPS - 1) % MAX_TAPS]),
        .coef_out  (coef_out[j]),
        .samp_out  (),
        .prod      (prod[j])
      );
    end
  end

  // products summed over clog2(MAX_TAPS) registered levels
  mff_sum_tree #(
    .N (MAX_TAPS)
  ) u_tree (
    .clk  (clk),
    .en   (advance),
    .leaf (prod),
    .root (filtered)
  );

  assign out_valid   = vld[PIPE-1];
  assign last_output = lst[PIPE-1];

  `MFF_ASSERT_NEXT(a_flush_load, acc_samp && last_sample, flush_cnt == $past(len_m1),
                   "tail count not loaded from tap count")
  `MFF_ASSERT_NEXT(a_flush_step, flushing && advance, flush_cnt == $past(flush_cnt) - 1'b1,
                   "tail count did not step down")
  `MFF_ASSERT_NEXT(a_run_end, push && push_last, flush_cnt == '0,
                   "tail still pending after final push")

endmodule
